FILE: hdl/oren_nayar_reflectance_defines.svh
// Assertion macros used by the checker file of the Oren-Nayar reflectance block.
`ifndef OREN_NAYAR_REFLECTANCE_DEFINES_SVH
`define OREN_NAYAR_REFLECTANCE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define ONR_ASSERT_ALWAYS(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Same-cycle implication.
`define ONR_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Delayed implication; n sets the delay before the consequent.
`define ONR_ASSERT_DELAY(lbl, ck, rn, ante, n, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> ##n (cons)) else $error(msg);

`endif

FILE: hdl/onr_pkg.sv
// Types and constants shared by the Oren-Nayar reflectance modules.
`default_nettype none
package onr_pkg;

  localparam int VEC_W = 16;
  localparam int FRAC = 15;
  localparam int SIN_W = FRAC + 1;
  localparam int SQ_W = 2 * FRAC + 2;
  localparam int DOT_W = 2 * VEC_W + 1;
  localparam int DEN_W = 2 * SIN_W;
  localparam int TAN_W = 32;
  localparam int CPHI_W = 17;
  localparam int SA_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;

  localparam int SQRT_STAGES = 8;
  localparam int DIV_STAGES = 16;
  localparam int SHADE_STAGES = 6;
  localparam int OUT_LATENCY = 4 + SQRT_STAGES + DIV_STAGES + SHADE_STAGES;

  localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * FRAC);
  localparam logic [29:0] ONE_VEC = 30'(1) << FRAC;
  localparam logic [13:0] SIN_SCALE = 14'd10000;
  localparam logic [CPHI_W-1:0] CPHI_ONE = 17'h10000;
  localparam logic [TAN_W-1:0] TAN_MAX = '1;
  localparam logic [22:0] INV_PI_Q24 = 23'd5340354;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_RED   = 3'd0,
    REG_COLOR_GREEN = 3'd1,
    REG_COLOR_BLUE  = 3'd2,
    REG_A_COEF      = 3'd3,
    REG_B_COEF      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] out_x;
    logic signed [VEC_W-1:0] out_y;
    logic signed [VEC_W-1:0] out_z;
    logic signed [VEC_W-1:0] in_x;
    logic signed [VEC_W-1:0] in_y;
    logic signed [VEC_W-1:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic [15:0] refl_red;
    logic [15:0] refl_green;
    logic [15:0] refl_blue;
  } out_item_t;

  typedef struct packed {
    logic [15:0] color_red;
    logic [15:0] color_green;
    logic [15:0] color_blue;
    logic [16:0] a_coef;
    logic [15:0] b_coef;
  } cfg_t;

endpackage
`default_nettype wire

FILE: hdl/oren_nayar_reflectance.sv
// Top level of the pipelined Oren-Nayar diffuse reflectance evaluator.
//
// One transaction is accepted in every cycle (busy stays low) and its result appears on
// out_data with out_valid after passing through the 8-stage square-root pipeline, the
// 16-stage divider pipeline for cosphi and tan beta, the six stages of the colour multiply
// chain and four alignment stages. The result stream has no back pressure, so the pipeline
// never stalls. Configuration registers are read live and must be written only while no
// transaction is in flight.
`default_nettype none
module oren_nayar_reflectance
  import onr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic valid_r [OUT_LATENCY];

  logic [2*VEC_W-2:0]       zz_o_r, zz_i_r;
  logic signed [2*VEC_W-1:0] px_r, py_r;
  logic [VEC_W-1:0]         abs_o1_r, abs_i1_r;

  logic [SQ_W-1:0]          rad_o_r, rad_i_r;
  logic signed [DOT_W-1:0]  dot2_r;
  logic [VEC_W-1:0]         abs_o2_r, abs_i2_r;

  logic signed [DOT_W-1:0]  dot_d_r   [SQRT_STAGES];
  logic [VEC_W-1:0]         abs_o_d_r [SQRT_STAGES];
  logic [VEC_W-1:0]         abs_i_d_r [SQRT_STAGES];

  logic [SIN_W-1:0] sin_o, sin_i;
  logic [DEN_W-1:0] den_r;
  logic             thr_r;
  logic signed [DOT_W-1:0] dot3_r;
  logic [SIN_W-1:0] sa_r, sb_r;
  logic [VEC_W-1:0] cb_r;

  logic [DEN_W-1:0] cnum_r, cden_r;
  logic             csat_r, tsat_r;
  logic [TAN_W-1:0] tbits_r;
  logic [VEC_W-1:0] tden_r;
  logic [SIN_W-1:0] sa4_r;

  logic [SIN_W-1:0] sa_d_r   [DIV_STAGES];
  logic             csat_d_r [DIV_STAGES];
  logic             tsat_d_r [DIV_STAGES];

  logic [15:0]       cquo;
  logic [TAN_W-1:0]  tquo;
  logic [CPHI_W-1:0] cphi;
  logic [TAN_W-1:0]  tan_b;
  logic [SIN_W+15:0] sa_ext;
  logic [SA_W-1:0]   sa16;

  logic signed [2*VEC_W-1:0] zz_o_full, zz_i_full;
  logic [29:0] thr_prod_o, thr_prod_i;
  logic        cvalid, cge;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.color_red <= '0;
      cfg_r.color_green <= '0;
      cfg_r.color_blue <= '0;
      cfg_r.a_coef <= 17'h10000;
      cfg_r.b_coef <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_COLOR_RED:   cfg_r.color_red <= cfg_wdata[15:0];
        REG_COLOR_GREEN: cfg_r.color_green <= cfg_wdata[15:0];
        REG_COLOR_BLUE:  cfg_r.color_blue <= cfg_wdata[15:0];
        REG_A_COEF:      cfg_r.a_coef <= cfg_wdata[16:0];
        REG_B_COEF:      cfg_r.b_coef <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < OUT_LATENCY; k++) begin
        valid_r[k] <= 1'b0;
      end
    end else begin
      valid_r[0] <= start && !busy;
      for (int k = 1; k < OUT_LATENCY; k++) begin
        valid_r[k] <= valid_r[k-1];
      end
    end
  end

  assign zz_o_full = in_data.out_z * in_data.out_z;
  assign zz_i_full = in_data.in_z * in_data.in_z;

  always_ff @(posedge clk) begin
    zz_o_r <= zz_o_full[2*VEC_W-2:0];
    zz_i_r <= zz_i_full[2*VEC_W-2:0];
    px_r <= in_data.in_x * in_data.out_x;
    py_r <= in_data.in_y * in_data.out_y;
    abs_o1_r <= in_data.out_z[VEC_W-1] ? VEC_W'(-in_data.out_z) : in_data.out_z;
    abs_i1_r <= in_data.in_z[VEC_W-1] ? VEC_W'(-in_data.in_z) : in_data.in_z;
  end

  always_ff @(posedge clk) begin
    rad_o_r <= ({1'b0, zz_o_r} >= ONE_SQ) ? '0 : ONE_SQ - {1'b0, zz_o_r};
    rad_i_r <= ({1'b0, zz_i_r} >= ONE_SQ) ? '0 : ONE_SQ - {1'b0, zz_i_r};
    dot2_r <= DOT_W'(px_r) + DOT_W'(py_r);
    abs_o2_r <= abs_o1_r;
    abs_i2_r <= abs_i1_r;
  end

  onr_isqrt #(.IN_W(SQ_W), .STAGES(SQRT_STAGES)) u_sqrt_o (
    .clk(clk), .rad_i(rad_o_r), .root_o(sin_o)
  );

  onr_isqrt #(.IN_W(SQ_W), .STAGES(SQRT_STAGES)) u_sqrt_i (
    .clk(clk), .rad_i(rad_i_r), .root_o(sin_i)
  );

  always_ff @(posedge clk) begin
    dot_d_r[0] <= dot2_r;
    abs_o_d_r[0] <= abs_o2_r;
    abs_i_d_r[0] <= abs_i2_r;
    for (int k = 1; k < SQRT_STAGES; k++) begin
      dot_d_r[k] <= dot_d_r[k-1];
      abs_o_d_r[k] <= abs_o_d_r[k-1];
      abs_i_d_r[k] <= abs_i_d_r[k-1];
    end
  end

  assign thr_prod_o = 30'(sin_o) * 30'(SIN_SCALE);
  assign thr_prod_i = 30'(sin_i) * 30'(SIN_SCALE);

  always_ff @(posedge clk) begin
    den_r <= DEN_W'(sin_i) * DEN_W'(sin_o);
    thr_r <= (thr_prod_o > ONE_VEC) && (thr_prod_i > ONE_VEC);
    dot3_r <= dot_d_r[SQRT_STAGES-1];
    if (abs_i_d_r[SQRT_STAGES-1] > abs_o_d_r[SQRT_STAGES-1]) begin
      sa_r <= sin_o;
      sb_r <= sin_i;
      cb_r <= abs_i_d_r[SQRT_STAGES-1];
    end else begin
      sa_r <= sin_i;
      sb_r <= sin_o;
      cb_r <= abs_o_d_r[SQRT_STAGES-1];
    end
  end

  assign cvalid = thr_r && (dot3_r > 0);
  assign cge = {1'b0, dot3_r[DOT_W-2:0]} >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    csat_r <= cvalid && cge;
    cnum_r <= (cvalid && !cge) ? dot3_r[DEN_W-1:0] : '0;
    cden_r <= thr_r ? den_r : DEN_W'(1);
    tsat_r <= (cb_r == '0);
    tden_r <= (cb_r == '0) ? VEC_W'(1) : cb_r;
    tbits_r <= {sb_r, 16'b0};
    sa4_r <= sa_r;
  end

  onr_divider #(.DEN_W(DEN_W), .Q_W(16), .STAGES(DIV_STAGES)) u_div_cphi (
    .clk(clk), .rem0_i(cnum_r), .bits_i(16'b0), .den_i(cden_r), .quo_o(cquo)
  );

  onr_divider #(.DEN_W(VEC_W), .Q_W(TAN_W), .STAGES(DIV_STAGES)) u_div_tan (
    .clk(clk), .rem0_i(VEC_W'(0)), .bits_i(tbits_r), .den_i(tden_r), .quo_o(tquo)
  );

  always_ff @(posedge clk) begin
    sa_d_r[0] <= sa4_r;
    csat_d_r[0] <= csat_r;
    tsat_d_r[0] <= tsat_r;
    for (int k = 1; k < DIV_STAGES; k++) begin
      sa_d_r[k] <= sa_d_r[k-1];
      csat_d_r[k] <= csat_d_r[k-1];
      tsat_d_r[k] <= tsat_d_r[k-1];
    end
  end

  assign cphi = csat_d_r[DIV_STAGES-1] ? CPHI_ONE : {1'b0, cquo};
  assign tan_b = tsat_d_r[DIV_STAGES-1] ? TAN_MAX : tquo;
  assign sa_ext = {sa_d_r[DIV_STAGES-1], 16'b0};
  assign sa16 = sa_ext[FRAC +: SA_W];

  onr_shade u_shade (
    .clk(clk), .cfg(cfg_r), .cphi_i(cphi), .sa16_i(sa16), .tan_i(tan_b), .rgb_o(out_data)
  );

  assign out_valid = valid_r[OUT_LATENCY-1];

endmodule
`default_nettype wire

FILE: hdl/onr_isqrt.sv
// Pipelined digit-by-digit integer square root, floor result.
`default_nettype none
module onr_isqrt #(
  parameter int IN_W = 32,
  parameter int STAGES = 8
) (
  input  wire logic              clk,
  input  wire logic [IN_W-1:0]   rad_i,
  output logic [IN_W/2-1:0]      root_o
);

  localparam int RT_W = IN_W / 2;
  localparam int REM_W = RT_W + 2;
  localparam int STEPS = RT_W / STAGES;

  logic [IN_W-1:0]  rad_r  [STAGES];
  logic [REM_W-1:0] rem_r  [STAGES];
  logic [RT_W-1:0]  root_r [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [IN_W-1:0]  rad_in, rad_nxt;
    logic [REM_W-1:0] rem_in, rem_nxt;
    logic [RT_W-1:0]  root_in, root_nxt;

    if (s == 0) begin : g_first
      assign rad_in = rad_i;
      assign rem_in = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in = rad_r[s-1];
      assign rem_in = rem_r[s-1];
      assign root_in = root_r[s-1];
    end

    always_comb begin
      logic [REM_W-1:0] trial;
      rad_nxt = rad_in;
      rem_nxt = rem_in;
      root_nxt = root_in;
      trial = '0;
      for (int k = 0; k < STEPS; k++) begin
        rem_nxt = {rem_nxt[REM_W-3:0], rad_nxt[IN_W-1 -: 2]};
        rad_nxt = {rad_nxt[IN_W-3:0], 2'b00};
        trial = {root_nxt, 2'b01};
        if (rem_nxt >= trial) begin
          rem_nxt = rem_nxt - trial;
          root_nxt = {root_nxt[RT_W-2:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[RT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      rad_r[s] <= rad_nxt;
      rem_r[s] <= rem_nxt;
      root_r[s] <= root_nxt;
    end
  end

  assign root_o = root_r[STAGES-1];

endmodule
`default_nettype wire

FILE: hdl/onr_divider.sv
// Pipelined restoring divider with a starting remainder below the divisor.
`default_nettype none
module onr_divider #(
  parameter int DEN_W = 16,
  parameter int Q_W = 32,
  parameter int STAGES = 16
) (
  input  wire logic             clk,
  input  wire logic [DEN_W-1:0] rem0_i,
  input  wire logic [Q_W-1:0]   bits_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]        quo_o
);

  localparam int STEPS = Q_W / STAGES;

  logic [DEN_W-1:0] rem_r  [STAGES];
  logic [Q_W-1:0]   bits_r [STAGES];
  logic [Q_W-1:0]   quo_r  [STAGES];
  logic [DEN_W-1:0] den_r  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [DEN_W-1:0] rem_in, rem_nxt, den_in;
    logic [Q_W-1:0]   bits_in, bits_nxt, quo_in, quo_nxt;

    if (s == 0) begin : g_first
      assign rem_in = rem0_i;
      assign bits_in = bits_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign bits_in = bits_r[s-1];
      assign quo_in = quo_r[s-1];
      assign den_in = den_r[s-1];
    end

    always_comb begin
      logic [DEN_W:0] trial;
      rem_nxt = rem_in;
      bits_nxt = bits_in;
      quo_nxt = quo_in;
      trial = '0;
      for (int k = 0; k < STEPS; k++) begin
        trial = {rem_nxt, bits_nxt[Q_W-1]};
        bits_nxt = {bits_nxt[Q_W-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          trial = trial - {1'b0, den_in};
          quo_nxt = {quo_nxt[Q_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[Q_W-2:0], 1'b0};
        end
        rem_nxt = trial[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      bits_r[s] <= bits_nxt;
      quo_r[s] <= quo_nxt;
      den_r[s] <= den_in;
    end
  end

  assign quo_o = quo_r[STAGES-1];

endmodule
`default_nettype wire

FILE: hdl/onr_shade.sv
// Multiply pipeline from cosphi, sin alpha and tan beta to the saturated colour channels.
`default_nettype none
module onr_shade
  import onr_pkg::*;
(
  input  wire logic              clk,
  input  wire cfg_t              cfg,
  input  wire logic [CPHI_W-1:0] cphi_i,
  input  wire logic [SA_W-1:0]   sa16_i,
  input  wire logic [TAN_W-1:0]  tan_i,
  output out_item_t              rgb_o
);

  logic [15:0]      bc_r;
  logic [SA_W-1:0]  sa16_r;
  logic [TAN_W-1:0] tan1_r, tan2_r;
  logic [15:0]      bcs_r;
  logic [31:0]      term_r;
  logic [32:0]      factor_r;
  logic [17:0]      cf_r [3];
  out_item_t        rgb_r;

  logic [32:0] bc_prod, bcs_prod;
  logic [47:0] term_prod;
  logic [15:0] color [3];
  logic [17:0] cf_nxt [3];
  logic [15:0] chan_nxt [3];

  assign bc_prod = 33'(cfg.b_coef) * 33'(cphi_i);
  assign bcs_prod = 33'(bc_r) * 33'(sa16_r);
  assign term_prod = 48'(bcs_r) * 48'(tan2_r);

  assign color[0] = cfg.color_red;
  assign color[1] = cfg.color_green;
  assign color[2] = cfg.color_blue;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [48:0] cf_prod;
    logic [40:0] r_prod;
    assign cf_prod = 49'(color[c]) * 49'(factor_r);
    assign cf_nxt[c] = (cf_prod[48:34] != '0) ? '1 : cf_prod[33:16];
    assign r_prod = 41'(cf_r[c]) * 41'(INV_PI_Q24);
    assign chan_nxt[c] = r_prod[40] ? 16'hFFFF : r_prod[39:24];
  end

  always_ff @(posedge clk) begin
    bc_r <= bc_prod[31:16];
    sa16_r <= sa16_i;
    tan1_r <= tan_i;
    bcs_r <= bcs_prod[31:16];
    tan2_r <= tan1_r;
    term_r <= term_prod[47:16];
    factor_r <= 33'(cfg.a_coef) + 33'(term_r);
    for (int c = 0; c < 3; c++) begin
      cf_r[c] <= cf_nxt[c];
    end
    rgb_r.refl_red <= chan_nxt[0];
    rgb_r.refl_green <= chan_nxt[1];
    rgb_r.refl_blue <= chan_nxt[2];
  end

  assign rgb_o = rgb_r;

endmodule
`default_nettype wire

FILE: hdl/onr_checker.sv
// Port-level assertion checker for the Oren-Nayar reflectance block, with its bind.
`default_nettype none
`include "oren_nayar_reflectance_defines.svh"
module onr_checker
  import onr_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic cfg_valid,
  input wire logic cfg_ready
);

  `ONR_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy, "busy raised on a stall-free pipeline")
  `ONR_ASSERT_IMPL(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready, "config write not taken")
  `ONR_ASSERT_DELAY(a_result_follows, clk, rst_n, start && !busy, OUT_LATENCY, out_valid, "result missing after a transaction")
  `ONR_ASSERT_IMPL(a_no_spurious, clk, rst_n, out_valid, $past(start && !busy && rst_n, OUT_LATENCY), "result without a transaction")

endmodule

bind oren_nayar_reflectance onr_checker u_onr_checker (.*);
`default_nettype wire
